// ===== rtl/slcd_pkg.sv =====
// ----------------------------------------------------------------------------
// slcd_pkg: shared definitions for the sync/length/checksum deframer
// Holds the sync byte values, the byte role codes and the result item type.
// ----------------------------------------------------------------------------
`default_nettype none

package slcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ROLE_W = 3;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

  // Role codes carried with every passed-through byte.
  localparam logic [ROLE_W-1:0] ROLE_ADDR    = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_CMD     = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_DTYPE   = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_LEN     = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 3'd4;
  localparam logic [ROLE_W-1:0] ROLE_CHECK   = 3'd5;

  typedef struct packed {
    logic              checksum_good;
    logic              frame_last;
    logic [ROLE_W-1:0] byte_role;
    logic [BYTE_W-1:0] frame_byte;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/slcd_parser.sv =====
// ----------------------------------------------------------------------------
// slcd_parser: frame parse state and running checksum
// Classifies one byte per step and updates the phase, length and sum.
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_parser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic [slcd_pkg::BYTE_W-1:0]  rx_byte,
  output logic                              emit,
  output slcd_pkg::result_t                 result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC2,
    PH_ADDR,
    PH_CMD,
    PH_DTYPE,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  phase_t                        phase, phase_next;
  logic [slcd_pkg::BYTE_W-1:0]   bytes_left, bytes_left_next;
  logic [slcd_pkg::BYTE_W-1:0]   running_sum, running_sum_next;
  logic [slcd_pkg::BYTE_W-1:0]   sum_plus;
  logic [slcd_pkg::BYTE_W-1:0]   left_minus;

  assign sum_plus   = running_sum + rx_byte;
  assign left_minus = bytes_left - slcd_pkg::BYTE_W'(1);

  always_comb begin
    phase_next           = phase;
    bytes_left_next      = bytes_left;
    running_sum_next     = running_sum;
    emit                 = 1'b1;
    result.frame_byte    = rx_byte;
    result.byte_role     = slcd_pkg::ROLE_CHECK;
    result.frame_last    = 1'b0;
    result.checksum_good = 1'b0;
    case (phase)
      PH_IDLE: begin
        emit = 1'b0;
        if (rx_byte == slcd_pkg::SYNC_FIRST) begin
          phase_next = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        emit = 1'b0;
        if (rx_byte == slcd_pkg::SYNC_SECOND) begin
          phase_next       = PH_ADDR;
          running_sum_next = '0;
          bytes_left_next  = '0;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_ADDR: begin
        running_sum_next = sum_plus;
        phase_next       = PH_CMD;
        result.byte_role = slcd_pkg::ROLE_ADDR;
      end
      PH_CMD: begin
        running_sum_next = sum_plus;
        phase_next       = PH_DTYPE;
        result.byte_role = slcd_pkg::ROLE_CMD;
      end
      PH_DTYPE: begin
        running_sum_next = sum_plus;
        phase_next       = PH_LEN;
        result.byte_role = slcd_pkg::ROLE_DTYPE;
      end
      PH_LEN: begin
        running_sum_next = sum_plus;
        bytes_left_next  = rx_byte;
        phase_next       = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
        result.byte_role = slcd_pkg::ROLE_LEN;
      end
      PH_PAYLOAD: begin
        running_sum_next = sum_plus;
        bytes_left_next  = left_minus;
        if (left_minus == '0) begin
          phase_next = PH_CHECK;
        end
        result.byte_role = slcd_pkg::ROLE_PAYLOAD;
      end
      default: begin
        phase_next           = PH_IDLE;
        bytes_left_next      = '0;
        result.byte_role     = slcd_pkg::ROLE_CHECK;
        result.frame_last    = 1'b1;
        result.checksum_good = (rx_byte == running_sum);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bytes_left  <= '0;
      running_sum <= '0;
    end else if (step) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

  // The payload phase is only entered with a nonzero count and left at zero.
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_left != '0)
    else $error("payload phase with zero bytes left");

  // Leaving idle takes the first sync byte.
  a_idle_hunt: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && rx_byte != slcd_pkg::SYNC_FIRST |=> phase == PH_IDLE)
    else $error("hunt left idle without first sync byte");

  // Only the checksum phase produces a last-marked result.
  a_last_only_check: assert property (@(posedge clk) disable iff (rst)
    emit && result.frame_last |-> phase == PH_CHECK)
    else $error("last marker outside checksum phase");

endmodule

`default_nettype wire

// ===== rtl/sync_length_checksum_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer: byte stream deframer with additive checksum
// Finds AA 55 framed packets and passes their bytes out tagged by role.
// ----------------------------------------------------------------------------
// The block takes one received byte per item and hunts for the sync pair
// 0xAA then 0x55; a byte other than 0x55 right after 0xAA restarts the hunt
// and is not itself taken as a new 0xAA. After sync, the address, command,
// data type and length bytes come out, then as many payload bytes as the
// length gives (none for a zero length), and finally the checksum byte with
// tlast set and a flag saying whether it equals the modulo-256 sum of every
// byte from address through the last payload byte. Sync bytes and bytes
// outside a frame give no output item. The block accepts one byte every
// cycle unless the output side stalls it: the input register feeds the
// parse logic, whose result lands in the output register, so an accepted
// byte is held in the input register and then in the output register
// before it is presented on the master side. The output register frees
// itself in the same cycle that its item is taken, so a stall only blocks
// the input once both registers hold an item.
`default_nettype none

module sync_length_checksum_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] frame_byte
  output logic            m_axis_tlast,   // frame_last
  output logic [3:0]      m_axis_tuser    // [2:0] byte_role, [3] checksum_good
);

  logic                         in_valid;
  logic [slcd_pkg::BYTE_W-1:0]  in_byte;
  logic                         in_take;
  logic                         out_free;
  logic                         emit;
  slcd_pkg::result_t            parsed;
  logic                         out_valid;
  slcd_pkg::result_t            out_res;

  // The output register can load when empty or when its item leaves now.
  assign out_free = !out_valid || m_axis_tready;

  // A byte that produces no result never waits on the output side.
  assign in_take       = in_valid && (!emit || out_free);
  assign s_axis_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  slcd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (in_take),
    .rx_byte (in_byte),
    .emit    (emit),
    .result  (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      out_res <= parsed;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.frame_byte;
  assign m_axis_tlast  = out_res.frame_last;
  assign m_axis_tuser  = {out_res.checksum_good, out_res.byte_role};

  // A last-marked item always carries the checksum role.
  a_last_is_check: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2:0] == slcd_pkg::ROLE_CHECK)
    else $error("last item without checksum role");

  // The checksum flag is only raised on the last item of a frame.
  a_good_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[3])
    else $error("checksum flag set on a non-last item");

  // An item is only loaded into the output register when it has room.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_take && emit |-> out_free)
    else $error("result loaded over a pending item");

endmodule

`default_nettype wire

// ===== dv/sync_length_checksum_deframer_test.sv =====
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_test: self-checking bench for the deframer
// The bench streams byte items into the block and keeps a cycle-free
// predictor of the frame parser. Each tagged byte that leaves the block is
// checked field by field against the oldest predicted item. Both stream
// sides idle at random, and the sender stops now and then until all
// predicted items have been taken.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One byte waiting to be sent. When hold_until_empty is set, the driver
  // keeps the byte back until every predicted result has left the block.
  typedef struct {
    logic [7:0] value;
    bit         hold_until_empty;
  } rx_item_t;

  // Parser position, one step for each kind of byte in a frame.
  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    AT_ADDR,
    AT_CMD,
    AT_DTYPE,
    AT_LEN,
    AT_PAYLOAD,
    AT_CHECK
  } parse_step_t;

  localparam int IDLE_PERCENT   = 36;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [3:0] m_axis_tuser;

  sync_length_checksum_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] frame_byte
    .m_axis_tlast  (m_axis_tlast),   // frame_last
    .m_axis_tuser  (m_axis_tuser)    // [2:0] byte_role, [3] checksum_good
  );

  always #5 clk = ~clk;

  // Bytes still to be sent, and tagged bytes predicted but not yet seen.
  rx_item_t           rx_stream[$];
  slcd_pkg::result_t  tagged_bytes_due[$];

  // Predictor state, the testbench's own copy of the parser.
  parse_step_t step      = HUNT_FIRST;
  logic [7:0]  remaining = 8'd0;
  logic [7:0]  frame_sum = 8'd0;

  int unsigned error_count = 0;
  int unsigned rx_count    = 0;
  int unsigned quiet_cycles = 0;
  logic        rx_took     = 1'b0;
  slcd_pkg::result_t predicted;
  slcd_pkg::result_t oldest;

  // During this stretch of the run neither side idles, so the block sees
  // back-to-back items in both directions.
  wire no_idling = (rx_count >= 300) && (rx_count < 500);

  // Advances the parser by one byte. Returns 1 when the byte leaves the
  // block as a tagged item, and fills in what that item must carry.
  function automatic bit deframe_byte(input logic [7:0] b,
                                      output slcd_pkg::result_t out_item);
    bit emits;
    out_item = '0;
    out_item.frame_byte = b;
    emits = 1'b1;
    case (step)
      HUNT_FIRST: begin
        emits = 1'b0;
        if (b == slcd_pkg::SYNC_FIRST) step = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        // Anything but the second sync byte drops back to the hunt, and
        // that byte is never taken as a fresh first sync byte.
        emits = 1'b0;
        if (b == slcd_pkg::SYNC_SECOND) begin
          step      = AT_ADDR;
          frame_sum = 8'd0;
          remaining = 8'd0;
        end else begin
          step = HUNT_FIRST;
        end
      end
      AT_ADDR: begin
        out_item.byte_role = slcd_pkg::ROLE_ADDR;
        frame_sum += b;
        step = AT_CMD;
      end
      AT_CMD: begin
        out_item.byte_role = slcd_pkg::ROLE_CMD;
        frame_sum += b;
        step = AT_DTYPE;
      end
      AT_DTYPE: begin
        out_item.byte_role = slcd_pkg::ROLE_DTYPE;
        frame_sum += b;
        step = AT_LEN;
      end
      AT_LEN: begin
        // A zero length skips the payload and goes to the checksum byte.
        out_item.byte_role = slcd_pkg::ROLE_LEN;
        frame_sum += b;
        remaining = b;
        step = (b == 8'd0) ? AT_CHECK : AT_PAYLOAD;
      end
      AT_PAYLOAD: begin
        out_item.byte_role = slcd_pkg::ROLE_PAYLOAD;
        frame_sum += b;
        remaining -= 8'd1;
        if (remaining == 8'd0) step = AT_CHECK;
      end
      default: begin
        out_item.byte_role     = slcd_pkg::ROLE_CHECK;
        out_item.frame_last    = 1'b1;
        out_item.checksum_good = (b == frame_sum);
        step      = HUNT_FIRST;
        remaining = 8'd0;
      end
    endcase
    return emits;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input bit hold = 1'b0);
    rx_item_t item;
    item.value            = b;
    item.hold_until_empty = hold;
    rx_stream = {rx_stream, item};
  endtask

  // Queues a complete frame with random header and payload bytes. The
  // checksum is either the true sum or a deliberately different byte.
  task automatic queue_frame(input int unsigned len, input bit sum_ok, input bit hold);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'd0;
    queue_byte(slcd_pkg::SYNC_FIRST, hold);
    queue_byte(slcd_pkg::SYNC_SECOND);
    for (int i = 0; i < 3; i++) begin
      b = 8'($urandom_range(255));
      sum += b;
      queue_byte(b);
    end
    sum += 8'(len);
    queue_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      sum += b;
      queue_byte(b);
    end
    queue_byte(sum_ok ? sum : sum + 8'($urandom_range(255, 1)));
  endtask

  // Driver: inputs change on the falling edge. A new byte is offered only
  // once the previous one was taken at the last rising edge.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idling || ($urandom_range(99) >= IDLE_PERCENT);
      if (!s_axis_tvalid || rx_took) begin
        if (rx_stream.size() != 0 &&
            (no_idling || $urandom_range(99) >= IDLE_PERCENT) &&
            !(rx_stream[0].hold_until_empty && tagged_bytes_due.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_stream[0].value;
          void'(rx_stream.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: both handshakes are sampled on the rising edge. Accepted input
  // bytes run through the predictor; accepted output items are checked.
  always @(posedge clk) begin
    rx_took <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rx_count <= rx_count + 1;
        if (deframe_byte(s_axis_tdata, predicted))
          tagged_bytes_due = {tagged_bytes_due, predicted};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (tagged_bytes_due.size() == 0) begin
          $error("unexpected output item: frame_byte %0h role %0d last %0b good %0b",
                 m_axis_tdata, m_axis_tuser[2:0], m_axis_tlast, m_axis_tuser[3]);
          error_count++;
        end else begin
          oldest = tagged_bytes_due.pop_front();
          if (m_axis_tdata !== oldest.frame_byte) begin
            $error("frame_byte: expected %0h, got %0h", oldest.frame_byte, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tuser[2:0] !== oldest.byte_role) begin
            $error("byte_role: expected %0d, got %0d", oldest.byte_role, m_axis_tuser[2:0]);
            error_count++;
          end
          if (m_axis_tlast !== oldest.frame_last) begin
            $error("frame_last: expected %0b, got %0b", oldest.frame_last, m_axis_tlast);
            error_count++;
          end
          if (m_axis_tuser[3] !== oldest.checksum_good) begin
            $error("checksum_good: expected %0b, got %0b",
                   oldest.checksum_good, m_axis_tuser[3]);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no item moving on either side
  // means the block has hung.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned next_hold;
    logic [7:0]  b;

    // Bytes outside any frame give nothing.
    queue_byte(8'h00);
    queue_byte(8'hFF);
    // A second first-sync byte in the sync position is not a new start, so
    // the following second-sync byte is just noise.
    queue_byte(slcd_pkg::SYNC_FIRST);
    queue_byte(slcd_pkg::SYNC_FIRST);
    queue_byte(slcd_pkg::SYNC_SECOND);
    // Broken sync with an ordinary byte.
    queue_byte(slcd_pkg::SYNC_FIRST);
    queue_byte(8'h12);
    // Zero length frame with extreme header values and a good checksum:
    // 00 + FF + AA + 00 = A9.
    queue_byte(slcd_pkg::SYNC_FIRST);
    queue_byte(slcd_pkg::SYNC_SECOND);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'hAA);
    queue_byte(8'h00);
    queue_byte(8'hA9);
    // Sync values inside the payload are plain data, and the frame still
    // ends on a bad checksum (true sum is 59).
    queue_byte(slcd_pkg::SYNC_FIRST);
    queue_byte(slcd_pkg::SYNC_SECOND);
    queue_byte(8'h01);
    queue_byte(8'h02);
    queue_byte(slcd_pkg::SYNC_SECOND);
    queue_byte(8'h02);
    queue_byte(slcd_pkg::SYNC_FIRST);
    queue_byte(slcd_pkg::SYNC_SECOND);
    queue_byte(8'h00);

    // The longest payload the length byte allows, once.
    queue_frame(255, 1'b1, 1'b0);

    // Mostly well-formed frames of small length with random content, the
    // rest noise, broken sync pairs and frames cut short.
    next_hold = 250;
    while (rx_stream.size() < 1050) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_frame(($urandom_range(99) < 90) ? $urandom_range(6) : $urandom_range(40),
                    $urandom_range(3) != 0, rx_stream.size() >= next_hold);
        if (rx_stream.size() >= next_hold) next_hold += 300;
      end else if (pick < 80) begin
        repeat ($urandom_range(4, 1)) queue_byte(8'($urandom_range(255)));
      end else if (pick < 90) begin
        queue_byte(slcd_pkg::SYNC_FIRST);
        do b = ($urandom_range(3) == 0) ? slcd_pkg::SYNC_FIRST : 8'($urandom_range(255));
        while (b == slcd_pkg::SYNC_SECOND);
        queue_byte(b);
      end else begin
        // A frame that stops early; the bytes after it are parsed as its rest.
        queue_byte(slcd_pkg::SYNC_FIRST);
        queue_byte(slcd_pkg::SYNC_SECOND);
        repeat ($urandom_range(4)) queue_byte(8'($urandom_range(255)));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (rx_stream.size() != 0 || s_axis_tvalid || tagged_bytes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && tagged_bytes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
